// ===== sv/bqdm_pkg.sv =====
package bqdm_pkg;

   localparam int COST_W     = 31;
   localparam int SUM_W      = 43;
   localparam int QIDX_W     = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int LOW_W      = 7;
   localparam int HIGH_W     = 6;
   localparam int SCALE_W    = LOW_W + 1;
   localparam int DIFF_W     = COST_W + 1;
   localparam int PROD_W     = SCALE_W + DIFF_W;
   localparam int DSR_W      = 32;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
   localparam int OFF_W      = 7;
   localparam int QSUM_W     = QIDX_W + 2;

   localparam int OFFSET_LIMIT = 9 * 4 - 1;
   localparam int OFFSET_FLOOR = -9 * 4 + 1;

   localparam logic [QIDX_W-1:0] QINDEX_MIN = QIDX_W'(1);
   localparam logic [QIDX_W-1:0] QINDEX_MAX = QIDX_W'(255);

   localparam logic signed [LOW_W-1:0] LOW_SCALE_RESET  = -7'sd8;
   localparam logic [HIGH_W-1:0]       HIGH_SCALE_RESET = 6'd8;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMIT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_QINDEX     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTRA_FRAME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SIDE_SCALE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_SIDE_SCALE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COST_W-1:0] cost_value;
   } bqdm_req_type;

   typedef struct packed {
      logic [QIDX_W-1:0] qindex;
      logic              last_result;
   } bqdm_rsp_type;

endpackage

// ===== sv/block_qindex_from_distortion_map_unit.sv =====
// Per-block quantizer index from a motion-cost map. A start word clears the frame statistics,
// each load word stores one block cost in an internal memory of MAX_BLOCKS entries and updates
// the running sum, minimum and maximum, and each emit word returns the index of the next
// stored block in load order. An emit uses a shared radix-2 divider for the signed offset
// division; an emit that bypasses the offset (intra frame, both scales zero, or a zero span)
// skips that division. The first emit after any load also computes the frame average with the
// same divider. A finished result sits in an output register, so the next word is taken while
// it waits. The user must write configuration only while the block is idle; the block itself
// does not enforce it.
module block_qindex_from_distortion_map_unit
   import bqdm_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bqdm_req_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bqdm_rsp_type         rsp_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_AVG   = 6'b000010,
      S_DIFF  = 6'b000100,
      S_MUL   = 6'b001000,
      S_START = 6'b010000,
      S_DIV   = 6'b100000
   } state_type;

   // out_pend_ff marks a finished result that waits until the output register is free.
   state_type state_ff, state_in;
   logic      out_pend_ff, out_pend_in;

   logic [QIDX_W-1:0]            base_ff, base_in;
   logic                         intra_ff, intra_in;
   logic signed [LOW_W-1:0]      low_ff, low_in;
   logic [HIGH_W-1:0]            high_ff, high_in;

   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [COST_W-1:0]            min_ff, min_in;
   logic [COST_W-1:0]            max_ff, max_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             rdpos_ff, rdpos_in;
   logic [COST_W-1:0]            avg_ff, avg_in;
   logic                         avg_ready_ff, avg_ready_in;

   logic signed [DIFF_W-1:0]     diff_ff, diff_in;
   logic signed [DIFF_W-1:0]     span_ff, span_in;
   logic signed [SCALE_W-1:0]    scale_ff, scale_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic                         neg_ff, neg_in;
   logic signed [OFF_W-1:0]      off_ff, off_in;

   logic [SUM_W-1:0]             div_quo_ff, div_quo_in;
   logic [DSR_W-1:0]             div_rem_ff, div_rem_in;
   logic [DSR_W-1:0]             div_dsr_ff, div_dsr_in;
   logic [DIV_CNT_W-1:0]         div_cnt_ff, div_cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   bqdm_rsp_type                 rsp_word_ff, rsp_word_in;

   logic [COST_W-1:0]            value_store [MAX_BLOCKS];
   logic [COST_W-1:0]            mem_rdata_ff;
   logic                         mem_we;
   logic                         mem_rd_en;

   logic                         bypass;
   logic [DSR_W:0]               div_shift;
   logic [DSR_W:0]               div_sub;
   logic                         div_ge;
   logic [SUM_W:0]               sum_wide;
   logic                         diff_le;
   logic [PROD_W-1:0]            prod_mag;
   logic [DIFF_W-1:0]            span_mag;
   logic [OFF_W-2:0]             off_mag;
   logic signed [QSUM_W-1:0]     qsum;
   logic [QIDX_W-1:0]            qclip;

   assign req_stall = (state_ff != S_IDLE) || out_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign bypass = intra_ff || ((low_ff == '0) && (high_ff == '0));

   always_comb begin
      div_shift = {div_rem_ff, div_quo_ff[SUM_W-1]};
      div_ge    = div_shift >= {1'b0, div_dsr_ff};
      div_sub   = div_shift - {1'b0, div_dsr_ff};
      sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(req_word.cost_value);
      diff_in   = $signed({1'b0, mem_rdata_ff}) - $signed({1'b0, avg_ff});
      diff_le   = diff_in <= 0;
      prod_mag  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      span_mag  = span_ff[DIFF_W-1] ? DIFF_W'(-span_ff) : DIFF_W'(span_ff);
      off_mag   = (div_quo_ff > SUM_W'(OFFSET_LIMIT)) ? (OFF_W - 1)'(OFFSET_LIMIT)
                                                      : div_quo_ff[OFF_W-2:0];
      qsum      = $signed({2'b00, base_ff}) + QSUM_W'(off_ff);
      if (qsum < $signed({2'b00, QINDEX_MIN})) begin
         qclip = QINDEX_MIN;
      end else if (qsum > $signed({2'b00, QINDEX_MAX})) begin
         qclip = QINDEX_MAX;
      end else begin
         qclip = qsum[QIDX_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_pend_in  = out_pend_ff;
      base_in      = base_ff;
      intra_in     = intra_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      rdpos_in     = rdpos_ff;
      avg_in       = avg_ff;
      avg_ready_in = avg_ready_ff;
      span_in      = span_ff;
      scale_in     = scale_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      off_in       = off_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_dsr_in   = div_dsr_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;
      mem_rd_en    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_QINDEX:     base_in  = csr_wdata[QIDX_W-1:0];
            CSR_INTRA_FRAME:     intra_in = csr_wdata[0];
            CSR_LOW_SIDE_SCALE:  low_in   = $signed(csr_wdata[LOW_W-1:0]);
            CSR_HIGH_SIDE_SCALE: high_in  = csr_wdata[HIGH_W-1:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // One restoring step a cycle: quotient bits shift in where dividend bits leave.
      if (div_cnt_ff != '0) begin
         div_quo_in = {div_quo_ff[SUM_W-2:0], div_ge};
         div_rem_in = div_ge ? div_sub[DSR_W-1:0] : div_shift[DSR_W-1:0];
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      if (out_pend_ff) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_in            = 1'b1;
            rsp_word_in.qindex      = bypass ? base_ff : qclip;
            rsp_word_in.last_result = (rdpos_ff + CNT_W'(1)) == count_ff;
            rdpos_in                = rdpos_ff + CNT_W'(1);
            out_pend_in             = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  unique case (req_word.kind)
                     KIND_START: begin
                        sum_in       = '0;
                        min_in       = '1;
                        max_in       = '0;
                        count_in     = '0;
                        rdpos_in     = '0;
                        avg_in       = '0;
                        avg_ready_in = 1'b0;
                     end
                     KIND_LOAD: begin
                        if (count_ff < CNT_W'(MAX_BLOCKS)) begin
                           mem_we       = 1'b1;
                           count_in     = count_ff + CNT_W'(1);
                           sum_in       = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                           avg_ready_in = 1'b0;
                           if (req_word.cost_value < min_ff) begin
                              min_in = req_word.cost_value;
                           end
                           if (req_word.cost_value > max_ff) begin
                              max_in = req_word.cost_value;
                           end
                        end
                     end
                     KIND_EMIT: begin
                        if (rdpos_ff < count_ff) begin
                           mem_rd_en = 1'b1;
                           if (!avg_ready_ff) begin
                              div_quo_in = sum_ff;
                              div_rem_in = '0;
                              div_dsr_in = DSR_W'(count_ff);
                              div_cnt_in = DIV_CNT_W'(SUM_W);
                              state_in   = S_AVG;
                           end else begin
                              state_in = S_DIFF;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_AVG: begin
               if (div_cnt_ff == '0) begin
                  avg_in       = div_quo_ff[COST_W-1:0];
                  avg_ready_in = 1'b1;
                  state_in     = S_DIFF;
               end
            end
            S_DIFF: begin
               // At or below the average the span is negative or zero, above it positive.
               if (diff_le) begin
                  span_in  = $signed({1'b0, min_ff}) - $signed({1'b0, avg_ff});
                  scale_in = SCALE_W'(low_ff);
               end else begin
                  span_in  = $signed({1'b0, max_ff}) - $signed({1'b0, avg_ff});
                  scale_in = $signed({2'b00, high_ff});
               end
               state_in = S_MUL;
            end
            S_MUL: begin
               prod_in  = scale_ff * diff_ff;
               state_in = S_START;
            end
            S_START: begin
               if (bypass || (span_ff == '0)) begin
                  off_in      = '0;
                  out_pend_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  div_quo_in = SUM_W'(prod_mag);
                  div_rem_in = '0;
                  div_dsr_in = DSR_W'(span_mag);
                  div_cnt_in = DIV_CNT_W'(SUM_W);
                  neg_in     = prod_ff[PROD_W-1] ^ span_ff[DIFF_W-1];
                  state_in   = S_DIV;
               end
            end
            S_DIV: begin
               if (div_cnt_ff == '0) begin
                  off_in      = neg_ff ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
                  out_pend_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_pend_ff  <= 1'b0;
         base_ff      <= '0;
         intra_ff     <= 1'b0;
         low_ff       <= LOW_SCALE_RESET;
         high_ff      <= HIGH_SCALE_RESET;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         count_ff     <= '0;
         rdpos_ff     <= '0;
         avg_ff       <= '0;
         avg_ready_ff <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_pend_ff  <= out_pend_in;
         base_ff      <= base_in;
         intra_ff     <= intra_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         rdpos_ff     <= rdpos_in;
         avg_ff       <= avg_in;
         avg_ready_ff <= avg_ready_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= (state_ff == S_DIFF) ? diff_in : diff_ff;
      span_ff     <= span_in;
      scale_ff    <= scale_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      off_ff      <= off_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_dsr_ff  <= div_dsr_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_store[count_ff[ADDR_W-1:0]] <= req_word.cost_value;
      end
      if (mem_rd_en) begin
         mem_rdata_ff <= value_store[rdpos_ff[ADDR_W-1:0]];
      end
   end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bqdm_pkg::*;

   localparam int STORE_DEPTH   = 4096;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_WORDS   = 95;
   localparam int REPORT_LIMIT  = 10;
   localparam longint SUM_LIMIT = (longint'(1) << SUM_W) - 1;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum int {COST_WIDE, COST_NARROW, COST_FLAT, COST_EDGE} cost_style_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bqdm_req_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bqdm_rsp_type          rsp_word;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   block_qindex_from_distortion_map_unit #(
      .MAX_BLOCKS(STORE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Words waiting to be offered, and the index results they will cause.
   bqdm_req_type stim_words[$];
   bqdm_rsp_type expected_qidx[$];
   int           words_queued  = 0;
   int           error_count   = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_requests = 0;
   int           hold_seen     = 0;
   int           hold_left     = 0;

   // Shadow of the configuration and of the frame statistics.
   logic [QIDX_W-1:0] cfg_base  = '0;
   bit                cfg_intra = 1'b0;
   int                cfg_low   = -8;
   int                cfg_high  = 8;

   logic [COST_W-1:0] cost_mem[STORE_DEPTH];
   logic [SUM_W-1:0]  frame_sum = '0;
   logic [COST_W-1:0] frame_min = '1;
   logic [COST_W-1:0] frame_max = '0;
   logic [COST_W-1:0] frame_avg = '0;
   int                n_loaded  = 0;
   int                n_read    = 0;
   bit                avg_valid = 1'b0;

   function automatic logic [QIDX_W-1:0] qindex_for(logic [COST_W-1:0] cost);
      longint avg, delta, span, scale, offset, q;
      if (cfg_intra || (cfg_low == 0 && cfg_high == 0))
         return cfg_base;
      avg   = frame_avg;
      delta = cost;
      delta = delta - avg;
      if (delta <= 0) begin
         span  = frame_min;
         scale = cfg_low;
      end else begin
         span  = frame_max;
         scale = cfg_high;
      end
      span   = span - avg;
      offset = (span == 0) ? 0 : (scale * delta) / span;
      if (offset > OFFSET_LIMIT)
         offset = OFFSET_LIMIT;
      if (offset < OFFSET_FLOOR)
         offset = OFFSET_FLOOR;
      q = cfg_base;
      q = q + offset;
      if (q < 1)
         q = 1;
      if (q > 255)
         q = 255;
      return q[QIDX_W-1:0];
   endfunction

   task automatic predict_word(input bqdm_req_type w);
      longint       total;
      bqdm_rsp_type r;
      case (w.kind)
         KIND_START: begin
            frame_sum = '0;
            frame_min = '1;
            frame_max = '0;
            frame_avg = '0;
            n_loaded  = 0;
            n_read    = 0;
            avg_valid = 1'b0;
         end
         KIND_LOAD: begin
            if (n_loaded < STORE_DEPTH) begin
               cost_mem[n_loaded] = w.cost_value;
               n_loaded++;
               total = frame_sum;
               total = total + w.cost_value;
               frame_sum = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
               if (w.cost_value < frame_min)
                  frame_min = w.cost_value;
               if (w.cost_value > frame_max)
                  frame_max = w.cost_value;
               avg_valid = 1'b0;
            end
         end
         KIND_EMIT: begin
            if (n_read < n_loaded && n_read < STORE_DEPTH) begin
               if (!avg_valid) begin
                  frame_avg = COST_W'(frame_sum / n_loaded);
                  avg_valid = 1'b1;
               end
               r.qindex      = qindex_for(cost_mem[n_read]);
               r.last_result = (n_read + 1 == n_loaded);
               n_read++;
               expected_qidx.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // Request side: a word stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_word(req_word);
         if (!req_valid || !req_stall) begin
            if (stim_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_word  <= stim_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off, counted in cycles.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result side: compare each taken word with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_qidx.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("tb_top: unexpected result qindex=%0d last=%0b",
                           rsp_word.qindex, rsp_word.last_result);
            end else if (rsp_word !== expected_qidx[0]) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("tb_top: mismatch expected qindex=%0d last=%0b, got qindex=%0d last=%0b",
                           expected_qidx[0].qindex, expected_qidx[0].last_result,
                           rsp_word.qindex, rsp_word.last_result);
               void'(expected_qidx.pop_front());
            end else begin
               void'(expected_qidx.pop_front());
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [COST_W-1:0] cost);
      bqdm_req_type w;
      w.kind       = kind;
      w.cost_value = cost;
      stim_words.push_back(w);
      words_queued++;
   endtask

   function automatic logic [COST_W-1:0] pick_cost(cost_style_type style,
                                                   logic [COST_W-1:0] anchor);
      case (style)
         COST_WIDE:   return COST_W'($urandom);
         COST_NARROW: return COST_W'($urandom_range(0, 1000));
         COST_FLAT:   return anchor;
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return anchor + COST_W'($urandom_range(0, 3));
            endcase
         end
      endcase
   endfunction

   // One frame: start, loads, emits, with some frames broken on purpose.
   task automatic queue_frame();
      int                blocks, emits, split, i, j;
      cost_style_type    style;
      logic [COST_W-1:0] anchor;
      blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      style  = cost_style_type'($urandom_range(0, 3));
      anchor = COST_W'($urandom);
      if ($urandom_range(0, 9) != 0)
         queue_word(KIND_START, COST_W'($urandom));
      for (i = 0; i < blocks; i++)
         queue_word(KIND_LOAD, pick_cost(style, anchor));
      emits = blocks;
      case ($urandom_range(0, 9))
         0:       emits = blocks + $urandom_range(1, 2);
         1:       emits = $urandom_range(0, blocks);
         default: ;
      endcase
      split = ($urandom_range(0, 5) == 0) ? $urandom_range(0, emits) : -1;
      for (i = 0; i < emits; i++) begin
         if (i == split) begin
            for (j = $urandom_range(1, 3); j > 0; j--)
               queue_word(KIND_LOAD, pick_cost(style, anchor));
         end
         if ($urandom_range(0, 15) == 0)
            queue_word(KIND_UNUSED, COST_W'($urandom));
         queue_word(KIND_EMIT, COST_W'($urandom));
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
   endtask

   task automatic apply_settings(input int base, input int intra, input int low,
                                 input int high);
      logic [LOW_W-1:0]  low_bits;
      logic [HIGH_W-1:0] high_bits;
      low_bits  = low[LOW_W-1:0];
      high_bits = high[HIGH_W-1:0];
      write_reg(CSR_BASE_QINDEX, base[QIDX_W-1:0]);
      write_reg(CSR_INTRA_FRAME, CSR_DATA_W'(intra[0]));
      write_reg(CSR_LOW_SIDE_SCALE, CSR_DATA_W'(low_bits));
      write_reg(CSR_HIGH_SIDE_SCALE, CSR_DATA_W'(high_bits));
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_base  = base[QIDX_W-1:0];
      cfg_intra = intra[0];
      cfg_low   = low;
      cfg_high  = high;
   endtask

   // Wait until every word is taken and every result is back, then let the block settle.
   task automatic drain();
      do
         @(negedge clock);
      while (stim_words.size() != 0 || req_valid || expected_qidx.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase, target, i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      apply_settings(128, 0, -35, 35);
      @(negedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 65;
      // Emit with nothing loaded, then the unused kind.
      queue_word(KIND_EMIT, '1);
      queue_word(KIND_UNUSED, '1);
      queue_word(KIND_START, '0);
      queue_word(KIND_LOAD, '0);
      queue_word(KIND_LOAD, '1);
      queue_word(KIND_LOAD, COST_W'(1000));
      queue_word(KIND_LOAD, COST_W'(1000));
      for (i = 0; i < 5; i++)
         queue_word(KIND_EMIT, '0);
      // A flat frame has a zero span on both sides.
      queue_word(KIND_START, '1);
      queue_word(KIND_LOAD, COST_W'(5));
      queue_word(KIND_LOAD, COST_W'(5));
      queue_word(KIND_EMIT, '0);
      queue_word(KIND_EMIT, '0);
      // A load after emits have begun forces a new average.
      queue_word(KIND_LOAD, COST_W'(9));
      queue_word(KIND_EMIT, '0);
      queue_word(KIND_EMIT, '0);
      drain();

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: apply_settings(0, 0, -35, 35);
            1: apply_settings(255, 0, -35, 35);
            2: apply_settings($urandom_range(0, 255), 0, -int'($urandom_range(0, 35)),
                              $urandom_range(0, 35));
            3: apply_settings($urandom_range(0, 255), 1, -int'($urandom_range(1, 35)),
                              $urandom_range(1, 35));
            4: apply_settings($urandom_range(0, 255), 0, 0, 0);
            5: apply_settings(0, 1, -int'($urandom_range(0, 35)), $urandom_range(0, 35));
            6: apply_settings($urandom_range(0, 255), 0, 0, $urandom_range(1, 35));
            7: apply_settings($urandom_range(0, 255), 0, -int'($urandom_range(1, 35)), 0);
            default: apply_settings($urandom_range(1, 254), 0, -int'($urandom_range(1, 35)),
                                    $urandom_range(1, 35));
         endcase
         @(negedge clock);
         if (phase < 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 65;
         end else if (phase < 6) begin
            send_idle_pct = 65;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         target = words_queued + PHASE_WORDS;
         while (words_queued < target)
            queue_frame();
         // Long receiver hold-off while the sender keeps offering words.
         if (phase == 7)
            hold_requests++;
         drain();
      end

      if (error_count == 0 && expected_qidx.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
